// ===== src/upn_pkg.sv =====
// Shared types and constants of the unix path normalizer.
`default_nettype none

package upn_pkg;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int INDEX_W    = 12;
    localparam int LENGTH_W   = 13;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK         = 2'd0;
    localparam status_t STATUS_NOT_ABS    = 2'd1;
    localparam status_t STATUS_ABOVE_ROOT = 2'd2;
    localparam status_t STATUS_OVERFLOW   = 2'd3;

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_SEP   = 3'd1,
        ST_DOT1  = 3'd2,
        ST_DOT2  = 3'd3,
        ST_NAME  = 3'd4
    } scan_state_t;

    typedef struct packed {
        status_t               status;
        logic                  done_res;
        logic [LENGTH_W-1:0]   out_length;
        logic [7:0]            write_byte;
        logic [INDEX_W-1:0]    write_index;
        logic                  write_enable;
    } result_t;

endpackage

`default_nettype wire

// ===== src/upn_scan.sv =====
// Per-byte scanner step: next scan state, stack and length update, and the result item.
`default_nettype none

module upn_scan #(
    parameter int MAX_LEN     = 4096,
    parameter int STACK_DEPTH = 256,
    parameter int POS_W       = 13,
    parameter int TOP_W       = 9
) (
    input  upn_pkg::scan_state_t state_cur,
    input  logic [TOP_W-1:0]     top_cur,
    input  logic [POS_W-1:0]     pos_cur,
    input  upn_pkg::status_t     err_cur,
    input  logic [7:0]           path_byte,
    input  logic                 last,
    input  logic [POS_W-1:0]     mark1,
    input  logic [POS_W-1:0]     mark2,
    output upn_pkg::scan_state_t state_nxt,
    output logic [TOP_W-1:0]     top_nxt,
    output logic [POS_W-1:0]     pos_nxt,
    output upn_pkg::status_t     err_nxt,
    output logic                 push,
    output upn_pkg::result_t     result
);
    import upn_pkg::*;

    logic        is_slash;
    logic        is_dot;
    logic        emit_ok;
    logic        push_ok;
    logic        emit;
    scan_state_t state_step;
    logic [TOP_W-1:0] top_step;
    logic [POS_W-1:0] pos_step;
    status_t     err_step;
    logic [31:0] idx_wide;
    logic [31:0] len_wide;

    assign is_slash = (path_byte == CHAR_SLASH);
    assign is_dot   = (path_byte == CHAR_DOT);
    assign emit_ok  = (pos_cur < POS_W'(MAX_LEN));
    assign push_ok  = (top_cur < TOP_W'(STACK_DEPTH));

    // next state
    always_comb begin
        state_step = state_cur;
        top_step   = top_cur;
        pos_step   = pos_cur;
        err_step   = err_cur;
        emit       = 1'b0;
        push       = 1'b0;
        if (err_cur == STATUS_OK) begin
            case (state_cur)
                ST_SEP: begin
                    if (!is_slash) begin
                        if (!push_ok || !emit_ok) begin
                            err_step = STATUS_OVERFLOW;
                        end else begin
                            push       = 1'b1;
                            emit       = 1'b1;
                            top_step   = top_cur + TOP_W'(1);
                            pos_step   = pos_cur + POS_W'(1);
                            state_step = is_dot ? ST_DOT1 : ST_NAME;
                        end
                    end
                end
                ST_DOT1: begin
                    if (is_slash) begin
                        if (top_cur == '0) begin
                            err_step = STATUS_ABOVE_ROOT;
                        end else begin
                            top_step   = top_cur - TOP_W'(1);
                            pos_step   = mark1;
                            state_step = ST_SEP;
                        end
                    end else if (emit_ok) begin
                        emit       = 1'b1;
                        pos_step   = pos_cur + POS_W'(1);
                        state_step = is_dot ? ST_DOT2 : ST_NAME;
                    end else begin
                        err_step = STATUS_OVERFLOW;
                    end
                end
                ST_DOT2: begin
                    if (is_slash) begin
                        if (top_cur <= TOP_W'(1)) begin
                            err_step = STATUS_ABOVE_ROOT;
                        end else begin
                            top_step   = top_cur - TOP_W'(1) - TOP_W'(1);
                            pos_step   = mark2;
                            state_step = ST_SEP;
                        end
                    end else if (emit_ok) begin
                        emit       = 1'b1;
                        pos_step   = pos_cur + POS_W'(1);
                        state_step = ST_NAME;
                    end else begin
                        err_step = STATUS_OVERFLOW;
                    end
                end
                ST_NAME: begin
                    if (emit_ok) begin
                        emit     = 1'b1;
                        pos_step = pos_cur + POS_W'(1);
                        if (is_slash) begin
                            state_step = ST_SEP;
                        end
                    end else begin
                        err_step = STATUS_OVERFLOW;
                    end
                end
                default: begin
                    if (!is_slash) begin
                        err_step = STATUS_NOT_ABS;
                    end else if (emit_ok) begin
                        emit       = 1'b1;
                        pos_step   = pos_cur + POS_W'(1);
                        state_step = ST_SEP;
                    end else begin
                        err_step = STATUS_OVERFLOW;
                    end
                end
            endcase
        end
    end

    // path done: back to reset values
    always_comb begin
        if (last) begin
            state_nxt = ST_START;
            top_nxt   = '0;
            pos_nxt   = '0;
            err_nxt   = STATUS_OK;
        end else begin
            state_nxt = state_step;
            top_nxt   = top_step;
            pos_nxt   = pos_step;
            err_nxt   = err_step;
        end
    end

    assign idx_wide = 32'(pos_cur);
    assign len_wide = 32'(pos_step);

    // result item
    always_comb begin
        result.status   = err_step;
        result.done_res = last;
        if (emit && (err_step == STATUS_OK)) begin
            result.write_enable = 1'b1;
            result.write_index  = idx_wide[INDEX_W-1:0];
            result.write_byte   = path_byte;
        end else begin
            result.write_enable = 1'b0;
            result.write_index  = '0;
            result.write_byte   = '0;
        end
        if (err_step != STATUS_OK) begin
            result.out_length = '0;
        end else begin
            result.out_length = len_wide[LENGTH_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/unix_path_normalizer.sv =====
// Top level of the streaming unix path normalizer.
// An accepted input item passes the input register, then the result register (m_axis_tvalid).
// Throughput: one item per cycle unless the output stalls; the two newest component marks sit
// in flip-flops and the mark memory is read at two addresses every cycle, so a double pop never waits.
// Reset: synchronous, active low; clears the scanner, stack pointer, length and handshake
// state. The mark memory is not cleared. All scanner state returns to reset after a last item.
`default_nettype none

module unix_path_normalizer #(
    parameter int MAX_LEN     = 4096,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [upn_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] path_byte
    input  wire logic                            s_axis_tlast,  // last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] write_enable, [12:1] write_index, [20:13] write_byte, [33:21] out_length, zero above
    output logic [upn_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast,  // done_res
    output logic [upn_pkg::M_TUSER_W-1:0]        m_axis_tuser   // [1:0] status
);
    import upn_pkg::*;

    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;

    scan_state_t      state_reg, state_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    status_t          err_reg, err_next;
    logic             push_flag_reg, push_flag_next;
    logic [POS_W-1:0] push_val_reg;

    logic [POS_W-1:0] mark_mem [MEM_DEPTH];
    logic [POS_W-1:0] rd1_reg;
    logic [POS_W-1:0] rd2_reg;
    logic [TOP_W-1:0] rd1_ptr;
    logic [TOP_W-1:0] rd2_ptr;

    logic             advance;
    logic             fire;
    logic             push;
    logic [POS_W-1:0] mark1;
    logic [POS_W-1:0] mark2;
    scan_state_t      state_nxt;
    logic [TOP_W-1:0] top_nxt;
    logic [POS_W-1:0] pos_nxt;
    status_t          err_nxt;
    result_t          step_res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // marks right after a push: newest is in push_val_reg, the one below was read last cycle
    assign mark1 = push_flag_reg ? push_val_reg : rd1_reg;
    assign mark2 = push_flag_reg ? rd1_reg : rd2_reg;

    upn_scan #(
        .MAX_LEN     (MAX_LEN),
        .STACK_DEPTH (STACK_DEPTH),
        .POS_W       (POS_W),
        .TOP_W       (TOP_W)
    ) u_scan (
        .state_cur (state_reg),
        .top_cur   (top_reg),
        .pos_cur   (pos_reg),
        .err_cur   (err_reg),
        .path_byte (in_byte_reg),
        .last      (in_last_reg),
        .mark1     (mark1),
        .mark2     (mark2),
        .state_nxt (state_nxt),
        .top_nxt   (top_nxt),
        .pos_nxt   (pos_nxt),
        .err_nxt   (err_nxt),
        .push      (push),
        .result    (step_res)
    );

    always_comb begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        state_next     = fire ? state_nxt : state_reg;
        top_next       = fire ? top_nxt : top_reg;
        pos_next       = fire ? pos_nxt : pos_reg;
        err_next       = fire ? err_nxt : err_reg;
        push_flag_next = fire && push && !in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_START;
            top_reg       <= '0;
            pos_reg       <= '0;
            err_reg       <= STATUS_OK;
            push_flag_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            top_reg       <= top_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            push_flag_reg <= push_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_last_reg <= s_axis_tlast;
        end
        if (fire) begin
            out_res_reg <= step_res;
        end
        if (fire && push) begin
            push_val_reg <= pos_reg;
        end
    end

    assign rd1_ptr = top_reg - TOP_W'(1);
    assign rd2_ptr = top_reg - TOP_W'(1) - TOP_W'(1);

    // mark memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (fire && push) begin
            mark_mem[top_reg[ADDR_W-1:0]] <= pos_reg;
        end
        rd1_reg <= mark_mem[rd1_ptr[ADDR_W-1:0]];
        rd2_reg <= mark_mem[rd2_ptr[ADDR_W-1:0]];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (M_TDATA_W - LENGTH_W - 8 - INDEX_W - 1)'(0),
        out_res_reg.out_length,
        out_res_reg.write_byte,
        out_res_reg.write_index,
        out_res_reg.write_enable
    };
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

// ===== src/upn_checker.sv =====
// Port-level checks for the unix path normalizer, bound to the top level.
`default_nettype none

module upn_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [upn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input wire logic                            s_axis_tlast,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [upn_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic                            m_axis_tlast,
    input wire logic [upn_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import upn_pkg::*;

    logic                first_path_reg, first_path_next;
    logic                res_we;
    logic [INDEX_W-1:0]  res_idx;
    logic [7:0]          res_byte;
    logic [LENGTH_W-1:0] res_len;
    logic                first_ok;
    logic                first_err;
    logic                in_seen;

    assign res_we   = m_axis_tdata[0];
    assign res_idx  = m_axis_tdata[12:1];
    assign res_byte = m_axis_tdata[20:13];
    assign res_len  = m_axis_tdata[33:21];
    assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tlast);

    assign first_ok  = (m_axis_tuser == STATUS_OK) && res_we && (res_idx == '0)
                       && (res_byte == CHAR_SLASH) && (res_len == LENGTH_W'(1));
    assign first_err = (m_axis_tuser == STATUS_NOT_ABS) && !res_we && (res_len == '0);

    always_comb begin
        first_path_next = first_path_reg;
        if (m_axis_tvalid && m_axis_tready) begin
            first_path_next = m_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_path_reg <= 1'b1;
        end else begin
            first_path_reg <= first_path_next;
        end
    end

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("upn: stalled result item changed");

    // an error result writes nothing and reports length zero
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> !res_we && (res_len == '0))
        else $error("upn: error result carries a write or a length");

    // first result of a path: root slash at index 0, or not absolute
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && first_path_reg |-> first_ok || first_err)
        else $error("upn: bad first result of a path");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("upn: result valid after reset");

    // a first cycle out of reset that accepts no input item is not followed by a result
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn ##1 (aresetn && !in_seen && !(s_axis_tvalid && s_axis_tready))
            |=> !m_axis_tvalid)
        else $error("upn: result without an input item");

endmodule

bind unix_path_normalizer upn_checker u_upn_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_unix_path_normalizer.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the unix path normalizer: directed, limit and random paths.
module tb_unix_path_normalizer;
    import upn_pkg::*;

    localparam int MAX_LEN       = 4096;
    localparam int STACK_DEPTH   = 256;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef logic [7:0] path_t[$];

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    unix_path_normalizer #(
        .MAX_LEN     (MAX_LEN),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // normalizer model state
    scan_state_t            pn_state;
    logic [LENGTH_W-1:0]    comp_start [STACK_DEPTH];
    int unsigned            comp_top;
    int unsigned            norm_len;
    status_t                path_err;
    result_t                cur_edit;

    result_t                expected_edits[$];
    result_t                want;
    int unsigned            fail_count = 0;
    int unsigned            items_sent = 0;
    int unsigned            burst_left = 0;
    int unsigned            cycle_count = 0;
    int unsigned            rx_hold = 0;
    int unsigned            rx_mode = 0;

    function automatic void clear_path();
        pn_state = ST_START;
        comp_top = 0;
        norm_len = 0;
        path_err = STATUS_OK;
    endfunction

    function automatic bit put_byte(input logic [7:0] b);
        if (norm_len >= MAX_LEN) begin
            path_err = STATUS_OVERFLOW;
            return 1'b0;
        end
        cur_edit.write_enable = 1'b1;
        cur_edit.write_index = norm_len[INDEX_W-1:0];
        cur_edit.write_byte = b;
        norm_len++;
        return 1'b1;
    endfunction

    function automatic bit open_component();
        if (comp_top >= STACK_DEPTH) begin
            path_err = STATUS_OVERFLOW;
            return 1'b0;
        end
        comp_start[comp_top] = norm_len[LENGTH_W-1:0];
        comp_top++;
        return 1'b1;
    endfunction

    function automatic bit drop_component();
        if (comp_top == 0) begin
            path_err = STATUS_ABOVE_ROOT;
            return 1'b0;
        end
        comp_top--;
        norm_len = 32'(comp_start[comp_top]);
        return 1'b1;
    endfunction

    function automatic void predict_edit(input logic [7:0] b, input logic l);
        bit is_slash;
        bit is_dot;
        is_slash = (b == CHAR_SLASH);
        is_dot = (b == CHAR_DOT);
        cur_edit = '0;
        if (path_err == STATUS_OK) begin
            case (pn_state)
                ST_SEP: begin
                    if (is_dot) begin
                        if (open_component() && put_byte(b)) pn_state = ST_DOT1;
                    end else if (!is_slash) begin
                        if (open_component() && put_byte(b)) pn_state = ST_NAME;
                    end
                end
                ST_DOT1: begin
                    if (is_slash) begin
                        if (drop_component()) pn_state = ST_SEP;
                    end else if (put_byte(b)) begin
                        pn_state = is_dot ? ST_DOT2 : ST_NAME;
                    end
                end
                ST_DOT2: begin
                    if (is_slash) begin
                        if (drop_component() && drop_component()) pn_state = ST_SEP;
                    end else if (put_byte(b)) begin
                        pn_state = ST_NAME;
                    end
                end
                ST_NAME: begin
                    if (put_byte(b) && is_slash) pn_state = ST_SEP;
                end
                default: begin
                    if (is_slash) begin
                        if (put_byte(b)) pn_state = ST_SEP;
                    end else begin
                        path_err = STATUS_NOT_ABS;
                    end
                end
            endcase
            if (path_err != STATUS_OK) begin
                cur_edit.write_enable = 1'b0;
                cur_edit.write_index = '0;
                cur_edit.write_byte = '0;
            end
        end
        cur_edit.out_length = (path_err != STATUS_OK) ? '0 : norm_len[LENGTH_W-1:0];
        cur_edit.done_res = l;
        cur_edit.status = path_err;
        expected_edits.push_back(cur_edit);
        if (l) clear_path();
    endfunction

    task automatic send_item(input logic [7:0] b, input logic l);
        int unsigned idle_cycles;
        if (burst_left == 0) begin
            idle_cycles = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
        predict_edit(b, l);
    endtask

    task automatic send_path(input path_t p);
        for (int i = 0; i < p.size(); i++) send_item(p[i], i == p.size() - 1);
    endtask

    function automatic path_t to_path(input string s);
        path_t p;
        for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
        return p;
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) return CHAR_DOT;
        do b = 8'($urandom_range(1, 255)); while (b == CHAR_SLASH);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0, 1: return CHAR_SLASH;
            2: return CHAR_DOT;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // repeated slashes, dot, dot-dot, extreme bytes, trailing dot, errors
    task automatic test_directed_paths();
        path_t p;
        p = to_path("//?/./?/../c/.");
        p[2] = 8'h01;
        p[6] = 8'hFF;
        send_path(to_path("/"));
        send_path(p);
        send_path(to_path("x/"));
        send_path(to_path("/../"));
        send_path(to_path("/a/.."));
    endtask

    task automatic test_full_stack();
        path_t p;
        p = {CHAR_SLASH};
        repeat (STACK_DEPTH - 1) begin
            p.push_back(8'h61);
            p.push_back(CHAR_SLASH);
        end
        p.push_back(8'h61);
        send_path(p);
        p = {CHAR_SLASH};
        repeat (STACK_DEPTH) begin
            p.push_back(8'h61);
            p.push_back(CHAR_SLASH);
        end
        p.push_back(8'h61);
        p.push_back(8'h62);
        send_path(p);
    endtask

    task automatic test_random_paths();
        path_t p;
        int unsigned kind;
        int unsigned n_comp;
        int unsigned n_chars;
        int unsigned start_cnt;
        start_cnt = items_sent;
        while (items_sent - start_cnt < RANDOM_ITEMS) begin
            p = {};
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                n_chars = $urandom_range(1, 12);
                repeat (n_chars) p.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 3)) p.push_back(CHAR_SLASH);
                if (kind == 2) p[0] = name_byte();
                n_comp = $urandom_range(0, 8);
                for (int i = 0; i < n_comp; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1: p.push_back(CHAR_DOT);
                        2, 3: begin
                            p.push_back(CHAR_DOT);
                            p.push_back(CHAR_DOT);
                        end
                        4: begin
                            p.push_back(CHAR_DOT);
                            p.push_back(name_byte());
                        end
                        5: begin
                            p.push_back(CHAR_DOT);
                            p.push_back(CHAR_DOT);
                            p.push_back(name_byte());
                        end
                        default: begin
                            n_chars = $urandom_range(1, 6);
                            repeat (n_chars) p.push_back(name_byte());
                        end
                    endcase
                    if (kind == 3 && $urandom_range(0, 3) == 0) p.push_back(noise_byte());
                    if (i != n_comp - 1 || $urandom_range(0, 1) == 1)
                        repeat ($urandom_range(1, 3)) p.push_back(CHAR_SLASH);
                end
            end
            send_path(p);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("unix_path_normalizer test failed");
            $finish;
        end
    end

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_edits.size() == 0) begin
                $error("result item with no expected edit");
                fail_count++;
            end else begin
                want = expected_edits.pop_front();
                check_field("write_enable", want.write_enable, m_axis_tdata[0]);
                check_field("write_index", want.write_index, m_axis_tdata[12:1]);
                check_field("write_byte", want.write_byte, m_axis_tdata[20:13]);
                check_field("out_length", want.out_length, m_axis_tdata[33:21]);
                check_field("tdata_pad", 0, m_axis_tdata[M_TDATA_W-1:34]);
                check_field("done_res", want.done_res, m_axis_tlast);
                check_field("status", want.status, m_axis_tuser);
            end
        end
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_hold <= $urandom_range(32, 256);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((cycle_count % 7) < 3);
        endcase
    end

    initial begin
        clear_path();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed_paths();
        test_full_stack();
        test_random_paths();
        s_axis_tvalid <= 1'b0;
        while (expected_edits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("unix_path_normalizer test passed");
        end else begin
            $display("unix_path_normalizer test failed");
        end
        $finish;
    end

endmodule

// ===== unix_path_normalizer.f =====
src/upn_pkg.sv
src/upn_scan.sv
src/unix_path_normalizer.sv
src/upn_checker.sv
tb/sv/tb_unix_path_normalizer.sv
